// ===== design/magnetometer_minmax_calibrate_scale_top_defines.svh =====
// Assertion macros for the magnetometer calibration block
`ifndef MAGNETOMETER_MINMAX_CALIBRATE_SCALE_TOP_DEFINES_SVH
`define MAGNETOMETER_MINMAX_CALIBRATE_SCALE_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define MMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define MMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mmc_pkg.sv =====
//------------------------------------------------------------------------------
// mmc_pkg
// Shared types and constants for the magnetometer calibration block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package mmc_pkg;
    localparam int NUM_AXES      = 3;
    localparam int DISCARD_DEF   = 100;
    localparam int S14_DEF       = 50;
    localparam int S16_DEF       = 200;
    localparam int MG_NUM        = 49120;
    localparam int DEN_14        = 8190;
    localparam int DEN_16        = 32760;
    localparam logic [15:0] SCALE_ONE = 16'd4096;
    localparam logic [15:0] SCALE_MAX = 16'd32767;

    localparam logic [2:0] REG_RANGE  = 3'd0;
    localparam logic [2:0] REG_ADJ_X  = 3'd1;
    localparam logic [2:0] REG_ADJ_Z  = 3'd3;
    localparam logic [2:0] REG_BIAS_X = 3'd4;
    localparam logic [2:0] REG_BIAS_Z = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_CAL   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [15:0] x_raw;
        logic [15:0] y_raw;
        logic [15:0] z_raw;
        logic        overflow;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] x_cal;
        logic [16:0] y_cal;
        logic [16:0] z_cal;
        logic [31:0] x_scaled;
        logic [31:0] y_scaled;
        logic [31:0] z_scaled;
    } t_out;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] data;
    } t_cfg;

    // lane control from the sequencer
    typedef struct packed {
        logic start;    // load operands
        logic track;    // update min/max with sample
        logic reload;   // reset min/max
    } t_lane_ctl;
endpackage

// ===== design/mmc_if.sv =====
//------------------------------------------------------------------------------
// mmc_if
// Valid/ready channel carrying one payload.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
interface mmc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/mmc_div.sv =====
//------------------------------------------------------------------------------
// mmc_div
// Restoring unsigned divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mmc_div #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_quo, n_quo;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy, r_done;
    logic [DW:0]   w_sh;

    always_comb begin
        w_sh   = {r_rem[DW-1:0], r_quo[NW-1]};
        n_quo  = {r_quo[NW-2:0], 1'b0};
        n_rem  = w_sh;
        n_cnt  = r_cnt - 1'b1;
        n_busy = r_busy;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem    = w_sh - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
        if (r_cnt == CW'(1)) n_busy = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !n_busy;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= n_busy;
            end
        end
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= CW'(NW);
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_cnt <= n_cnt;
        end
    end
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== design/mmc_lane.sv =====
//------------------------------------------------------------------------------
// mmc_lane
// One axis: min/max tracking, bias removal and scaling product, rounded
// and divided by the range denominator with a short fold loop.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mmc_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mmc_pkg::t_lane_ctl    i_ctl,
    input  logic [15:0]           i_raw,
    input  logic [15:0]           i_bias,
    input  logic [7:0]            i_adj,
    input  logic [15:0]           i_scale,
    input  logic                  i_range,
    output logic [16:0]           o_cal,
    output logic [31:0]           o_scaled,
    output logic                  o_done,
    output logic signed [15:0]    o_max,
    output logic signed [15:0]    o_min
);
    import mmc_pkg::*;
    localparam int PW = 64;
    localparam int RW = 44;
    localparam logic [31:0] D14 = 32'(DEN_14 * 4096);
    localparam logic [31:0] D16 = 32'(DEN_16 * 4096);
    localparam logic [RW-1:0] FOLD_BASE = RW'(4096);
    localparam logic [RW-1:0] FOLD_DIV  = RW'(4095);

    logic signed [15:0] r_max, r_min;
    logic signed [16:0] r_d;
    logic [16:0]        r_mag;
    logic [32:0]        r_p1;    // mag * 49120
    logic [24:0]        r_p2;    // (adj+128) * scale
    logic [PW-1:0]      r_p;
    logic [2:0]         r_ph;
    logic               r_neg;
    logic [31:0]        w_den;
    logic [RW-1:0]      r_r;
    logic [31:0]        r_q;
    logic               r_busy, r_done;
    logic signed [32:0] w_sq;

    assign w_den = i_range ? D16 : D14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= -16'sd32767;
            r_min <= 16'sd32767;
            r_ph  <= '0;
        end else begin
            if (i_ctl.reload) begin
                r_max <= -16'sd32767;
                r_min <= 16'sd32767;
            end else if (i_ctl.track) begin
                if ($signed(i_raw) > r_max) r_max <= $signed(i_raw);
                if ($signed(i_raw) < r_min) r_min <= $signed(i_raw);
            end
            r_ph <= {r_ph[1:0], i_ctl.start};
        end
        if (i_ctl.start) begin
            r_d <= $signed({i_raw[15], i_raw}) - $signed({i_bias[15], i_bias});
        end
        if (r_ph[0]) begin
            r_neg <= r_d[16];
            r_mag <= r_d[16] ? 17'(-r_d) : 17'(r_d);
            r_p2  <= 25'({1'b0, i_adj} + 9'd128) * 25'(i_scale);
        end
        if (r_ph[1]) r_p1 <= 33'(r_mag) * 33'(MG_NUM);
        if (r_ph[2]) r_p <= PW'(r_p1) * PW'(r_p2) + PW'(w_den >> 1);
    end

    // r_p settles in the cycle after r_ph[2]
    logic r_go;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_go <= 1'b0;
        else          r_go <= r_ph[2];
    end

    // den = 4095 << 13 (14-bit) or 4095 << 15 (16-bit): the shift floors
    // exactly, then 4095 = 2^12 - 1 is removed by folding 12-bit digits,
    // at most four folds plus one closing step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_r < FOLD_BASE);
            if (r_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_r < FOLD_BASE)) begin
                r_busy <= 1'b0;
            end
        end
        if (r_go) begin
            r_r <= i_range ? RW'(r_p >> 15) : RW'(r_p >> 13);
            r_q <= '0;
        end else if (r_busy) begin
            if (r_r >= FOLD_BASE) begin
                r_q <= r_q + 32'(r_r >> 12);
                r_r <= (r_r >> 12) + RW'(r_r[11:0]);
            end else if (r_r == FOLD_DIV) begin
                r_q <= r_q + 32'd1;
            end
        end
    end

    always_comb begin
        w_sq = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        if (w_sq > 33'sd2147483647) o_scaled = 32'h7FFF_FFFF;
        else if (w_sq < -33'sd2147483648) o_scaled = 32'h8000_0000;
        else o_scaled = w_sq[31:0];
    end
    assign o_cal  = r_d;
    assign o_done = r_done;
    assign o_max  = r_max;
    assign o_min  = r_min;
endmodule

// ===== design/magnetometer_minmax_calibrate_scale_top.sv =====
//------------------------------------------------------------------------------
// magnetometer_minmax_calibrate_scale_top
// Three axis lanes plus a merge stage that ends calibration.
//------------------------------------------------------------------------------
// channel  | dir | payload
// in_ch    | in  | cmd, x/y/z_raw, overflow
// out_ch   | out | status, x/y/z_cal, x/y/z_scaled
// cfg_ch   | in  | index, data
// Data sample: the result waits on the lane multiply pipeline and up to four
// fold steps of the divide by 4095.
// Command, overflow and calibrating samples go straight to the output; the last
// calibration sample also runs three 32-step divides in the shared divider.
// Reset is synchronous; a stalled output holds the block until taken.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module magnetometer_minmax_calibrate_scale_top #(
    parameter int DISCARD_COUNT = mmc_pkg::DISCARD_DEF,
    parameter int SAMPLES_14BIT = mmc_pkg::S14_DEF,
    parameter int SAMPLES_16BIT = mmc_pkg::S16_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    mmc_if.sink   in_ch,
    mmc_if.source out_ch,
    mmc_if.sink   cfg_ch
);
    import mmc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_LANE = 6'b000010, S_HALF = 6'b000100,
        S_DIV  = 6'b001000, S_NEXT = 6'b010000, S_OUT  = 6'b100000
    } t_state;

    t_state        r_st;
    logic          r_range;
    logic [7:0]    r_adj [NUM_AXES];
    logic [15:0]   r_bias [NUM_AXES];
    logic [15:0]   r_scale [NUM_AXES];
    logic [8:0]    r_cnt;
    logic          r_calib;
    t_in           r_in;
    t_out          r_out;
    logic          r_ovalid;
    logic [1:0]    r_ax;
    logic [14:0]   r_half [NUM_AXES];
    logic [16:0]   r_sum;
    t_lane_ctl     w_ctl;
    logic [16:0]   w_cal [NUM_AXES];
    logic [31:0]   w_scl [NUM_AXES];
    logic [NUM_AXES-1:0] w_ldone;
    logic signed [15:0] w_max [NUM_AXES];
    logic signed [15:0] w_min [NUM_AXES];
    logic [15:0]   w_raw [NUM_AXES];
    logic [NUM_AXES-1:0] r_lgot;
    logic          r_dstart, w_ddone;
    logic [31:0]   w_dq;
    logic [8:0]    w_target, w_cnt1;
    logic          r_fin;

    assign w_raw[0] = r_in.x_raw;
    assign w_raw[1] = r_in.y_raw;
    assign w_raw[2] = r_in.z_raw;
    assign w_target = 9'(DISCARD_COUNT) + (r_range ? 9'(SAMPLES_16BIT) : 9'(SAMPLES_14BIT));
    assign w_cnt1   = r_cnt + 9'd1;

    assign in_ch.ready  = (r_st == S_IDLE) && !r_ovalid;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    always_comb begin
        w_ctl.start  = (r_st == S_LANE) && !r_in.cmd && !r_in.overflow && !r_calib;
        w_ctl.track  = (r_st == S_LANE) && !r_in.cmd && !r_in.overflow && r_calib
                       && (r_cnt >= 9'(DISCARD_COUNT));
        w_ctl.reload = (r_st == S_LANE) && r_in.cmd;
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        mmc_lane u_lane (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_raw(w_raw[a]),
            .i_bias(r_bias[a]), .i_adj(r_adj[a]), .i_scale(r_scale[a]),
            .i_range(r_range), .o_cal(w_cal[a]), .o_scaled(w_scl[a]),
            .o_done(w_ldone[a]), .o_max(w_max[a]), .o_min(w_min[a])
        );
    end

    // shared divider for soft-iron scale: (2*S*4096 + 3h) / (6h)
    logic [31:0] w_dnum, w_dden;
    assign w_dnum = {2'b0, r_sum, 13'b0} + 32'(3 * 32'(r_half[r_ax]));
    assign w_dden = 32'(6 * 32'(r_half[r_ax]));
    mmc_div #(.NW(32), .DW(32)) u_sdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_done(w_ddone), .o_quo(w_dq)
    );

    logic signed [16:0] w_bs [NUM_AXES];
    logic signed [16:0] w_hs [NUM_AXES];
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_bs[a] = 17'(w_max[a]) + 17'(w_min[a]);
            w_hs[a] = 17'(w_max[a]) - 17'(w_min[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_range  <= 1'b1;
            r_cnt    <= '0;
            r_calib  <= 1'b0;
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
            r_lgot   <= '0;
            r_fin    <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_adj[a]   <= 8'd128;
                r_bias[a]  <= '0;
                r_scale[a] <= SCALE_ONE;
            end
        end else begin
            r_dstart <= (r_st == S_NEXT) ||
                        ((r_st == S_DIV) && r_fin && w_ddone && (r_ax != 2'd2));
            if (cfg_ch.valid) begin
                if (cfg_ch.data.index == REG_RANGE) r_range <= cfg_ch.data.data[0];
                else if (cfg_ch.data.index >= REG_ADJ_X && cfg_ch.data.index <= REG_ADJ_Z)
                    r_adj[2'(cfg_ch.data.index - REG_ADJ_X)] <= cfg_ch.data.data[7:0];
                else if (cfg_ch.data.index >= REG_BIAS_X && cfg_ch.data.index <= REG_BIAS_Z)
                    r_bias[2'(cfg_ch.data.index - REG_BIAS_X)] <= cfg_ch.data.data;
            end
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_in <= in_ch.data;
                        r_st <= S_LANE;
                    end
                end
                S_LANE: begin
                    r_lgot <= '0;
                    if (r_in.cmd) begin
                        r_cnt <= '0;
                        r_calib <= 1'b1;
                        r_out <= '{status: ST_CAL, default: '0};
                        r_st <= S_OUT;
                    end else if (r_in.overflow) begin
                        r_out <= '{status: ST_OVF, default: '0};
                        r_st <= S_OUT;
                    end else if (r_calib) begin
                        r_cnt <= w_cnt1;
                        r_out <= '{status: ST_CAL, default: '0};
                        r_st <= (w_cnt1 >= w_target) ? S_HALF : S_OUT;
                    end else begin
                        r_fin <= 1'b0;
                        r_st <= S_DIV;
                    end
                end
                S_HALF: begin
                    // min/max now include the last sample
                    r_sum <= '0;
                    for (int a = 0; a < NUM_AXES; a++) begin
                        r_bias[a] <= 16'((w_bs[a] + (w_bs[a] < 0 ? 17'sd1 : 17'sd0)) >>> 1);
                        r_half[a] <= w_hs[a] < 0 ? 15'd0 : 15'(w_hs[a] >>> 1);
                    end
                    r_ax  <= '0;
                    r_fin <= 1'b1;
                    r_st  <= S_NEXT;
                end
                S_NEXT: begin
                    r_sum <= 17'(r_half[0]) + 17'(r_half[1]) + 17'(r_half[2]);
                    r_st <= S_DIV;
                end
                S_DIV: begin
                    if (r_fin) begin
                        if (w_ddone) begin
                            r_scale[r_ax] <= (r_half[r_ax] == '0) ? SCALE_ONE :
                                (w_dq > 32'(SCALE_MAX)) ? SCALE_MAX : w_dq[15:0];
                            if (r_ax == 2'd2) begin
                                r_calib <= 1'b0;
                                r_out.status <= ST_DONE;
                                r_st <= S_OUT;
                            end else begin
                                r_ax <= r_ax + 2'd1;
                            end
                        end
                    end else begin
                        r_lgot <= r_lgot | w_ldone;
                        if ((r_lgot | w_ldone) == '1) begin
                            r_out.status   <= ST_OK;
                            r_out.x_cal    <= w_cal[0];
                            r_out.y_cal    <= w_cal[1];
                            r_out.z_cal    <= w_cal[2];
                            r_out.x_scaled <= w_scl[0];
                            r_out.y_scaled <= w_scl[1];
                            r_out.z_scaled <= w_scl[2];
                            r_st <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/mmc_checker.sv =====
//------------------------------------------------------------------------------
// mmc_checker
// Port-level checks on the magnetometer calibration block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "magnetometer_minmax_calibrate_scale_top_defines.svh"
module mmc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_cmd,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] out_status,
    input logic [31:0] out_xs
);
    import mmc_pkg::*;
    `MMC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_status), "output changed while stalled")
    `MMC_ASSERT_IMP(a_one, i_clk, i_rst_n, out_valid, !in_ready, "input taken with result pending")
    `MMC_ASSERT_IMP(a_zero, i_clk, i_rst_n, out_valid && out_status != ST_OK, out_xs == '0, "non-data result carries data")
    `MMC_ASSERT_NEXT(a_cmd, i_clk, i_rst_n, in_valid && in_ready && in_cmd, !out_valid, "command result too early")
endmodule

bind magnetometer_minmax_calibrate_scale_top mmc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.data.cmd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(out_ch.data.status), .out_xs(out_ch.data.x_scaled)
);
